>>> design/flcs_pkg.sv
// flcs_pkg: shared types and codes for the free-list cell store.
// Used by flcs_mem, free_list_cell_store and flcs_checker. No dependencies.
`default_nettype none

package flcs_pkg;

	localparam int CELLS_DEF      = 64;
	localparam int TAG_BITS_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	// operation codes on func
	localparam logic [2:0] FN_ALLOC = 3'd0;
	localparam logic [2:0] FN_FREE  = 3'd1;
	localparam logic [2:0] FN_WRITE = 3'd2;
	localparam logic [2:0] FN_READ  = 3'd3;
	localparam logic [2:0] FN_COUNT = 3'd4;
	localparam logic [2:0] FN_CHECK = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_NO_TAG   = 2'd2;
	localparam logic [1:0] STAT_REJECTED = 2'd3;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_TAKE_RD,
		ST_TAKE_WR,
		ST_FR_READ,
		ST_FR_EVAL,
		ST_FR_TAIL,
		ST_SR_READ,
		ST_SR_EVAL,
		ST_CK_READ,
		ST_CK_EVAL
	} state_t;

	// write enables of the four cell arrays
	typedef struct packed {
		logic link;
		logic tag;
		logic val;
		logic free;
	} mem_we_t;

endpackage

`default_nettype wire

>>> design/flcs_mem.sv
// flcs_mem: cell arrays (link, tag, value, free flag), one shared write
// address and one shared read address, registered read data. Uses flcs_pkg.
`default_nettype none

module flcs_mem
	import flcs_pkg::*;
#(
	parameter int CELLS      = CELLS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW = $clog2(CELLS),
	localparam int LW = $clog2(CELLS + 1)
) (
	input  wire logic                  clk,
	input  wire mem_we_t               we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [LW-1:0]         wlink,
	input  wire logic [TAG_BITS-1:0]   wtag,
	input  wire logic [VALUE_BITS-1:0] wval,
	input  wire logic                  wfree,
	input  wire logic [AW-1:0]         raddr,
	output logic      [LW-1:0]         rlink,
	output logic      [TAG_BITS-1:0]   rtag,
	output logic      [VALUE_BITS-1:0] rval,
	output logic                       rfree
);

	logic [LW-1:0]         link_mem [CELLS];
	logic [TAG_BITS-1:0]   tag_mem  [CELLS];
	logic [VALUE_BITS-1:0] val_mem  [CELLS];
	logic                  free_mem [CELLS];

	always_ff @(posedge clk) begin
		if (we.link) begin
			link_mem[waddr] <= wlink;
		end
		if (we.tag) begin
			tag_mem[waddr] <= wtag;
		end
		if (we.val) begin
			val_mem[waddr] <= wval;
		end
		if (we.free) begin
			free_mem[waddr] <= wfree;
		end
		rlink <= link_mem[raddr];
		rtag  <= tag_mem[raddr];
		rval  <= val_mem[raddr];
		rfree <= free_mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/free_list_cell_store.sv
// free_list_cell_store: linked cell store with a free list, run by a small
// sequencer that walks chains through flcs_mem. Uses flcs_pkg, flcs_mem.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start / busy         | func, address, id_tag, value, chain_len,
//           |                      | first_of_chain
//  result   | done (1-cycle pulse) | status, cell_address, read_value,
//           |                      | free_cells, on_free_list
//
// Allocate, free count and check do not walk chains; free, write and read
// visit the chain cell by cell, and a free that splices adds a tail step.
// After reset a clearing pass initializes the arrays; busy stays high until
// it ends. The result shows for one cycle while busy is already low, so the
// next command can be taken in that same cycle.
`default_nettype none

module free_list_cell_store
	import flcs_pkg::*;
#(
	parameter int CELLS      = CELLS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW = $clog2(CELLS),
	localparam int LW = $clog2(CELLS + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [2:0]                   func,
	input  wire logic [AW-1:0]                address,
	input  wire logic [TAG_BITS-1:0]          id_tag,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic [LW-1:0]                chain_len,
	input  wire logic                         first_of_chain,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [AW-1:0]                     cell_address,
	output logic signed [VALUE_BITS-1:0]      read_value,
	output logic [LW-1:0]                     free_cells,
	output logic                              on_free_list
);

	localparam logic [LW-1:0] NULL_LINK = LW'(CELLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	state_t state_q, state_d;

	// command fields held for the transaction
	logic [2:0]            func_q;
	logic [AW-1:0]         addr_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [LW-1:0]         len_q;
	logic                  first_q;

	logic [AW-1:0] init_q, init_d;
	logic [LW-1:0] free_head_q, free_head_d;
	logic [LW-1:0] free_total_q, free_total_d;
	logic [LW-1:0] rem_q, rem_d;
	logic          rej_q, rej_d;
	logic [AW-1:0] last_cell_q, last_cell_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [AW-1:0] x_q, x_d;
	logic          walk_first_q, walk_first_d;
	logic [LW-1:0] steps_q, steps_d;
	logic [LW-1:0] steps_n;

	logic                  done_q;
	logic [1:0]            status_q;
	logic [AW-1:0]         cell_q;
	logic [VALUE_BITS-1:0] rdv_q;
	logic                  onfree_q;

	logic                  fin;
	logic [1:0]            res_status;
	logic [AW-1:0]         res_cell;
	logic [VALUE_BITS-1:0] res_rdv;
	logic                  res_onfree;

	mem_we_t               we;
	logic [AW-1:0]         waddr, raddr;
	logic [LW-1:0]         wlink, rlink;
	logic [TAG_BITS-1:0]   wtag, rtag;
	logic [VALUE_BITS-1:0] wval, rval;
	logic                  wfree, rfree;
	logic                  addr_ok;

	flcs_mem #(
		.CELLS(CELLS),
		.TAG_BITS(TAG_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_mem (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wlink(wlink),
		.wtag(wtag),
		.wval(wval),
		.wfree(wfree),
		.raddr(raddr),
		.rlink(rlink),
		.rtag(rtag),
		.rval(rval),
		.rfree(rfree)
	);

	assign addr_ok = LW'(addr_q) < NULL_LINK;
	assign steps_n = steps_q + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			init_q       <= '0;
			free_head_q  <= '0;
			free_total_q <= NULL_LINK;
			rem_q        <= '0;
			rej_q        <= 1'b0;
			last_cell_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			init_q       <= init_d;
			free_head_q  <= free_head_d;
			free_total_q <= free_total_d;
			rem_q        <= rem_d;
			rej_q        <= rej_d;
			last_cell_q  <= last_cell_d;
			done_q       <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			func_q  <= func;
			addr_q  <= address;
			tag_q   <= id_tag;
			value_q <= value;
			len_q   <= chain_len;
			first_q <= first_of_chain;
		end
		cur_q        <= cur_d;
		x_q          <= x_d;
		walk_first_q <= walk_first_d;
		steps_q      <= steps_d;
		if (fin) begin
			status_q <= res_status;
			cell_q   <= res_cell;
			rdv_q    <= res_rdv;
			onfree_q <= res_onfree;
		end
	end

	always_comb begin
		state_d      = state_q;
		init_d       = init_q;
		free_head_d  = free_head_q;
		free_total_d = free_total_q;
		rem_d        = rem_q;
		rej_d        = rej_q;
		last_cell_d  = last_cell_q;
		cur_d        = cur_q;
		x_d          = x_q;
		walk_first_d = walk_first_q;
		steps_d      = steps_q;
		fin          = 1'b0;
		res_status   = STAT_OK;
		res_cell     = '0;
		res_rdv      = '0;
		res_onfree   = 1'b0;
		we           = '0;
		waddr        = cur_q;
		wlink        = NULL_LINK;
		wtag         = tag_q;
		wval         = value_q;
		wfree        = 1'b1;
		raddr        = cur_q;

		case (state_q)
			ST_INIT: begin
				we     = '{link: 1'b1, tag: 1'b1, val: 1'b1, free: 1'b1};
				waddr  = init_q;
				wlink  = LW'(init_q) + LW'(1);
				wtag   = '0;
				wval   = '0;
				if (init_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end else begin
					init_d = init_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				// anything but a follow-on allocation item closes the open request
				if (func_q != FN_ALLOC || first_q) begin
					rem_d = '0;
					rej_d = 1'b0;
					if (!rej_q && rem_q != '0) begin
						we.link = 1'b1;
						waddr   = last_cell_q;
					end
				end
				state_d = ST_IDLE;
				case (func_q)
					FN_ALLOC: begin
						if (first_q) begin
							if (len_q == '0 || len_q > free_total_q) begin
								fin        = 1'b1;
								res_status = STAT_NO_SPACE;
								if (len_q != '0) begin
									rem_d = len_q - LW'(1);
									rej_d = len_q > LW'(1);
								end
							end else begin
								rem_d   = len_q - LW'(1);
								state_d = ST_TAKE_RD;
							end
						end else if (rem_q != '0 && rej_q) begin
							fin        = 1'b1;
							res_status = STAT_REJECTED;
							rem_d      = rem_q - LW'(1);
							rej_d      = rem_q != LW'(1);
						end else if (rem_q != '0) begin
							rem_d   = rem_q - LW'(1);
							state_d = ST_TAKE_RD;
						end else begin
							fin        = 1'b1;
							res_status = STAT_REJECTED;
						end
					end
					FN_FREE: begin
						if (addr_ok) begin
							cur_d        = addr_q;
							walk_first_d = 1'b1;
							state_d      = ST_FR_READ;
						end else begin
							fin = 1'b1;
						end
					end
					FN_WRITE, FN_READ: begin
						if (addr_ok) begin
							cur_d   = addr_q;
							steps_d = '0;
							state_d = ST_SR_READ;
						end else begin
							fin        = 1'b1;
							res_status = STAT_NO_TAG;
						end
					end
					FN_CHECK: begin
						if (addr_ok) begin
							state_d = ST_CK_READ;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_TAKE_RD: begin
				raddr = free_head_q[AW-1:0];
				if (free_head_q >= NULL_LINK) begin
					rem_d      = '0;
					fin        = 1'b1;
					res_status = STAT_NO_SPACE;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_TAKE_WR;
				end
			end
			ST_TAKE_WR: begin
				waddr    = free_head_q[AW-1:0];
				we.tag   = 1'b1;
				we.free  = 1'b1;
				wfree    = 1'b0;
				// the last cell of a request is terminated right away
				if (rem_q == '0) begin
					we.link = 1'b1;
				end else begin
					last_cell_d = free_head_q[AW-1:0];
				end
				free_head_d = rlink;
				if (free_total_q != '0) begin
					free_total_d = free_total_q - LW'(1);
				end
				fin      = 1'b1;
				res_cell = free_head_q[AW-1:0];
				state_d  = ST_IDLE;
			end
			ST_FR_READ: begin
				state_d = ST_FR_EVAL;
			end
			ST_FR_EVAL: begin
				if (rfree) begin
					if (walk_first_q) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FR_TAIL;
					end
				end else begin
					we.free      = 1'b1;
					free_total_d = free_total_q + LW'(1);
					x_d          = cur_q;
					walk_first_d = 1'b0;
					if (rlink >= NULL_LINK) begin
						state_d = ST_FR_TAIL;
					end else begin
						cur_d   = rlink[AW-1:0];
						state_d = ST_FR_READ;
					end
				end
			end
			ST_FR_TAIL: begin
				// splice the freed chain onto the front of the free list
				we.link     = 1'b1;
				waddr       = x_q;
				wlink       = free_head_q;
				free_head_d = LW'(addr_q);
				fin         = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SR_READ: begin
				state_d = ST_SR_EVAL;
			end
			ST_SR_EVAL: begin
				if (rtag == tag_q) begin
					if (func_q == FN_WRITE) begin
						we.val = 1'b1;
					end else begin
						res_rdv = rval;
					end
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if (rlink >= NULL_LINK || steps_n == NULL_LINK) begin
					fin        = 1'b1;
					res_status = STAT_NO_TAG;
					state_d    = ST_IDLE;
				end else begin
					cur_d   = rlink[AW-1:0];
					steps_d = steps_n;
					state_d = ST_SR_READ;
				end
			end
			ST_CK_READ: begin
				raddr   = addr_q;
				state_d = ST_CK_EVAL;
			end
			ST_CK_EVAL: begin
				res_onfree = rfree;
				fin        = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign status       = status_q;
	assign cell_address = cell_q;
	assign read_value   = signed'(rdv_q);
	assign free_cells   = free_total_q;
	assign on_free_list = onfree_q;

endmodule

`default_nettype wire

>>> design/flcs_checker.sv
// flcs_checker: port-level assertions for free_list_cell_store, bound to
// the top level below. Uses flcs_pkg.
`default_nettype none

module flcs_checker
	import flcs_pkg::*;
#(
	parameter int CELLS      = CELLS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW = $clog2(CELLS),
	localparam int LW = $clog2(CELLS + 1)
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic [1:0]                   status,
	input wire logic [AW-1:0]                cell_address,
	input wire logic signed [VALUE_BITS-1:0] read_value,
	input wire logic [LW-1:0]                free_cells,
	input wire logic                         on_free_list
);

	// a taken transaction raises busy in the cycle after it is accepted
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command taken but busy not raised");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> free_cells <= LW'(CELLS))
		else $error("free count above store size");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (on_free_list || read_value != '0 || cell_address != '0)
		|-> status == STAT_OK)
		else $error("payload set on a failed transaction");

endmodule

bind free_list_cell_store flcs_checker #(
	.CELLS(CELLS),
	.VALUE_BITS(VALUE_BITS)
) u_flcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.cell_address(cell_address),
	.read_value(read_value),
	.free_cells(free_cells),
	.on_free_list(on_free_list)
);

`default_nettype wire
